/* rtl/bpc_pkg.sv */
// Shared types, constants and helpers of the barometric compensation block.
// Used by bpc_mulq, bpc_div and baro_pressure_temp_compensation; depends on nothing.
package bpc_pkg;

    typedef logic signed [63:0] q32_t;

    typedef enum logic [1:0] {
        CFG_CAL_TEMP    = 2'd0,
        CFG_CAL_PRESS_A = 2'd1,
        CFG_CAL_PRESS_B = 2'd2,
        CFG_CAL_PRESS_C = 2'd3
    } cfg_idx_t;

    localparam q32_t Q_MAX     = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam q32_t Q_NEG_MAX = 64'sh8000_0000_0000_0001;

    // 128000 in Q32.
    localparam q32_t TF_OFFSET = 64'sh0001_F400_0000_0000;
    // 16 and 1 in Q32.
    localparam q32_t Q_SIXTEEN = 64'sh0000_0010_0000_0000;
    localparam q32_t Q_ONE     = 64'sh0000_0001_0000_0000;

    localparam logic signed [14:0] TEMP_MIN = -15'sd4000;
    localparam logic signed [14:0] TEMP_MAX = 15'sd8500;
    localparam logic [24:0] PRESS_MAX = 25'h1FF_FFFF;

    // Delay line lengths and pipeline depth, in register stages.
    localparam int TF_DLY     = 6;
    localparam int PRAW_DLY   = 16;
    localparam int NUM_DLY    = 4;
    localparam int PF_DLY     = 7;
    localparam int CENTI_DLY  = 102;
    localparam int NZ_DLY     = 86;
    localparam int PIPE_DEPTH = 108;

    function automatic q32_t sext16(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    // Signed sum clamped to plus or minus (2^63 - 1).
    function automatic q32_t add_sat(input q32_t a, input q32_t b);
        logic signed [64:0] s;
        q32_t r;
        s = 65'(a) + 65'(b);
        if (!s[64] && s[63]) begin
            r = Q_MAX;
        end else if (s[64] && (!s[63] || s[62:0] == '0)) begin
            r = Q_NEG_MAX;
        end else begin
            r = s[63:0];
        end
        return r;
    endfunction

endpackage

/* rtl/bpc_mulq.sv */
// Pipelined signed 64 x 64 multiply, rounded shift right and saturation, five stages.
// Depends on bpc_pkg.
module bpc_mulq (
    input  logic              aclk,
    input  logic              en,
    input  logic signed [63:0] a,
    input  logic signed [63:0] b,
    input  logic [5:0]        shift,
    output logic signed [63:0] y
);

    logic        neg_a_reg, neg_b_reg, neg_c_reg, neg_d_reg;
    logic [63:0] ua_reg, ub_reg;
    logic [63:0] p00_reg, p01_reg, p10_reg, p11_reg;
    logic [127:0] prod_reg, rprod_reg;
    logic [127:0] rnd;
    logic [127:0] shifted;
    logic signed [63:0] mag;

    always_comb begin
        rnd = (shift == 6'd0) ? 128'd0 : (128'd1 << (shift - 6'd1));
        shifted = rprod_reg >> shift;
        mag = (|shifted[127:63]) ? bpc_pkg::Q_MAX : $signed({1'b0, shifted[62:0]});
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            neg_a_reg <= a[63] ^ b[63];
            ua_reg    <= a[63] ? (~$unsigned(a) + 64'd1) : $unsigned(a);
            ub_reg    <= b[63] ? (~$unsigned(b) + 64'd1) : $unsigned(b);

            neg_b_reg <= neg_a_reg;
            p00_reg   <= ua_reg[31:0]  * ub_reg[31:0];
            p01_reg   <= ua_reg[31:0]  * ub_reg[63:32];
            p10_reg   <= ua_reg[63:32] * ub_reg[31:0];
            p11_reg   <= ua_reg[63:32] * ub_reg[63:32];

            neg_c_reg <= neg_b_reg;
            prod_reg  <= {64'd0, p00_reg} + {32'd0, p01_reg, 32'd0}
                       + {32'd0, p10_reg, 32'd0} + {p11_reg, 64'd0};

            neg_d_reg <= neg_c_reg;
            rprod_reg <= prod_reg + rnd;

            y <= neg_d_reg ? (64'sd0 - mag) : mag;
        end
    end

endmodule

/* rtl/bpc_div.sv */
// Pipelined Q32 divide: round(num * 2^32 / den), one quotient bit per stage, 67 stages.
// Depends on bpc_pkg.
module bpc_div (
    input  logic              aclk,
    input  logic              en,
    input  logic signed [63:0] num,
    input  logic signed [63:0] den,
    output logic signed [63:0] quo
);

    logic [63:0] rem_reg  [65];
    logic [63:0] quot_reg [65];
    logic [63:0] ud_reg   [65];
    logic [63:0] dlo_reg  [65];
    logic        neg_reg  [65];
    logic        sat_reg  [65];

    logic [63:0] rem_next  [64];
    logic [63:0] quot_next [64];

    logic [63:0] un, ud;
    logic        sat0;

    logic [63:0] q1_reg;
    logic        rnd_reg, neg1_reg, sat1_reg;
    logic [64:0] qv;
    logic signed [63:0] mag;

    always_comb begin
        un = num[63] ? (~$unsigned(num) + 64'd1) : $unsigned(num);
        ud = den[63] ? (~$unsigned(den) + 64'd1) : $unsigned(den);
        // The quotient reaches 2^63 exactly when un >= ud * 2^31.
        sat0 = (ud[63:33] == '0) && (un >= {ud[32:0], 31'd0});
    end

    always_comb begin
        logic [64:0] trial;
        trial = '0;
        for (int k = 0; k < 64; k++) begin
            trial = {rem_reg[k], dlo_reg[k][6'(63 - k)]};
            if (trial >= {1'b0, ud_reg[k]}) begin
                rem_next[k]  = 64'(trial - {1'b0, ud_reg[k]});
                quot_next[k] = quot_reg[k] | (64'd1 << (6'(63 - k)));
            end else begin
                rem_next[k]  = trial[63:0];
                quot_next[k] = quot_reg[k];
            end
        end
    end

    always_comb begin
        qv  = {1'b0, q1_reg} + {64'd0, rnd_reg};
        mag = (sat1_reg || qv[64] || qv[63]) ? bpc_pkg::Q_MAX : $signed({1'b0, qv[62:0]});
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // The upper half of the dividend leaves only un >> 32 as remainder.
            rem_reg[0]  <= {32'd0, un[63:32]};
            quot_reg[0] <= '0;
            ud_reg[0]   <= ud;
            dlo_reg[0]  <= {un[31:0], 32'd0};
            neg_reg[0]  <= num[63] ^ den[63];
            sat_reg[0]  <= sat0;
            for (int k = 0; k < 64; k++) begin
                rem_reg[k+1]  <= rem_next[k];
                quot_reg[k+1] <= quot_next[k];
                ud_reg[k+1]   <= ud_reg[k];
                dlo_reg[k+1]  <= dlo_reg[k];
                neg_reg[k+1]  <= neg_reg[k];
                sat_reg[k+1]  <= sat_reg[k];
            end

            q1_reg   <= quot_reg[64];
            rnd_reg  <= rem_reg[64] >= (ud_reg[64] - rem_reg[64]);
            neg1_reg <= neg_reg[64];
            sat1_reg <= sat_reg[64];

            quo <= neg1_reg ? (64'sd0 - mag) : mag;
        end
    end

endmodule

/* rtl/baro_pressure_temp_compensation.sv */
// Top level of the barometric pressure and temperature compensation pipeline.
// Depends on bpc_pkg, bpc_mulq and bpc_div.
//
//  Channel   Signals                   Beat contents (low bit up)
//  s_axis    tvalid tready tdata[47:0] press_msb, press_lsb, press_xlsb,
//                                      temp_msb, temp_lsb, temp_xlsb
//  m_axis    tvalid tready tdata[39:0] temperature_centi, pressure_q8
//            tuser[0]                  valid_res
//  cfg       wen index[1:0] wdata[63:0] calibration register write
//
// One beat is taken every cycle while the pipeline advances; the pressure path runs
// through the 67-stage divider and the six multiplier passes around it.
// Reset clears the stage valid bits, the output valid bit and the calibration words.
// The whole pipeline holds while the output register is full, not taken and the
// last stage carries a result; otherwise it keeps moving and takes new beats.
module baro_pressure_temp_compensation (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // press_msb, press_lsb, press_xlsb, temp_msb, temp_lsb, temp_xlsb
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // temperature_centi[14:0], pressure_q8[39:15]
    output logic [0:0]  m_axis_tuser,   // valid_res
    input  logic        cfg_wen,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_wdata
);

    typedef bpc_pkg::q32_t q32_t;

    logic [47:0] cal_temp_reg;
    logic [63:0] cal_press_a_reg, cal_press_b_reg;
    logic [15:0] cal_press_c_reg;

    logic [15:0] t1, p1;
    q32_t t2w, t3w, p2, p3, p4, p5, p6, p7, p8, p9;

    logic adv;
    logic [bpc_pkg::PIPE_DEPTH-1:0] vld_reg;
    logic m_valid_reg;

    logic [19:0] t_raw, p_raw;
    logic signed [21:0] ofs_s1_reg;
    logic [19:0]        praw_s1_reg;
    logic signed [43:0] sq_s2_reg;
    logic signed [37:0] lin_s2_reg;
    logic signed [59:0] sqt_s3_reg, lins_s3_reg;
    logic signed [59:0] n34_s4_reg;
    logic signed [62:0] n5_s5_reg;
    q32_t               tf_s5_reg;
    logic signed [14:0] centi_s6_reg;

    logic [59:0] n34_mag;
    logic [57:0] n4;
    q32_t        tf_next;
    logic [62:0] n5_mag;
    logic [20:0] centi_r;
    logic signed [14:0] centi_next;

    q32_t tf_dly_reg   [bpc_pkg::TF_DLY];
    logic [19:0] praw_dly_reg [bpc_pkg::PRAW_DLY];
    q32_t num_dly_reg  [bpc_pkg::NUM_DLY];
    q32_t pf_dly_reg   [bpc_pkg::PF_DLY];
    logic signed [14:0] centi_dly_reg [bpc_pkg::CENTI_DLY];
    logic nz_dly_reg   [bpc_pkg::NZ_DLY];

    q32_t m1a_y, m1b_y, m2a_y, m2b_y, den_y, qd_y, pf_y, m5_y, m6_y;
    q32_t x1a_s11_reg, qa_s11_reg, x1_s17_reg, qb_s17_reg, num_s18_reg;
    q32_t pra_s100_reg, prb_s101_reg, prc_s107_reg;
    q32_t p4_term;
    logic [24:0] pq8_next;
    logic [24:0] pq8_s108_reg;
    logic [40:0] pq8_r;

    logic signed [14:0] centi_out_reg;
    logic [24:0]        press_out_reg;
    logic               valid_out_reg;

    // Calibration fields.
    assign t1  = cal_temp_reg[15:0];
    assign t2w = bpc_pkg::sext16(cal_temp_reg[31:16]);
    assign t3w = bpc_pkg::sext16(cal_temp_reg[47:32]);
    assign p1  = cal_press_a_reg[15:0];
    assign p2  = bpc_pkg::sext16(cal_press_a_reg[31:16]);
    assign p3  = bpc_pkg::sext16(cal_press_a_reg[47:32]);
    assign p4  = bpc_pkg::sext16(cal_press_a_reg[63:48]);
    assign p5  = bpc_pkg::sext16(cal_press_b_reg[15:0]);
    assign p6  = bpc_pkg::sext16(cal_press_b_reg[31:16]);
    assign p7  = bpc_pkg::sext16(cal_press_b_reg[47:32]);
    assign p8  = bpc_pkg::sext16(cal_press_b_reg[63:48]);
    assign p9  = bpc_pkg::sext16(cal_press_c_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_temp_reg    <= '0;
            cal_press_a_reg <= '0;
            cal_press_b_reg <= '0;
            cal_press_c_reg <= '0;
        end else if (cfg_wen) begin
            unique case (bpc_pkg::cfg_idx_t'(cfg_index))
                bpc_pkg::CFG_CAL_TEMP:    cal_temp_reg    <= cfg_wdata[47:0];
                bpc_pkg::CFG_CAL_PRESS_A: cal_press_a_reg <= cfg_wdata;
                bpc_pkg::CFG_CAL_PRESS_B: cal_press_b_reg <= cfg_wdata;
                bpc_pkg::CFG_CAL_PRESS_C: cal_press_c_reg <= cfg_wdata[15:0];
            endcase
        end
    end

    // Flow control.
    assign adv           = !vld_reg[bpc_pkg::PIPE_DEPTH-1] || !m_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {press_out_reg, centi_out_reg};
    assign m_axis_tuser  = valid_out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (adv) begin
                vld_reg <= {vld_reg[bpc_pkg::PIPE_DEPTH-2:0], s_axis_tvalid};
            end
            if (!m_valid_reg || m_axis_tready) begin
                m_valid_reg <= vld_reg[bpc_pkg::PIPE_DEPTH-1];
            end
        end
    end

    // Temperature front end.
    assign p_raw = {s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:20]};
    assign t_raw = {s_axis_tdata[31:24], s_axis_tdata[39:32], s_axis_tdata[47:44]};

    always_comb begin
        n34_mag = n34_s4_reg[59] ? 60'(-n34_s4_reg) : 60'(n34_s4_reg);
        n4      = 58'((n34_mag + 60'd2) >> 2);
        tf_next = (n34_s4_reg[59] ? (64'sd0 - $signed({6'd0, n4})) : $signed({6'd0, n4}))
                - bpc_pkg::TF_OFFSET;

        n5_mag  = n5_s5_reg[62] ? 63'(-n5_s5_reg) : 63'(n5_s5_reg);
        centi_r = 21'((n5_mag + (63'd1 << 41)) >> 42);
        if (n5_s5_reg[62]) begin
            centi_next = (centi_r > 21'd4000) ? bpc_pkg::TEMP_MIN
                                              : $signed(15'd0 - centi_r[14:0]);
        end else begin
            centi_next = (centi_r > 21'd8500) ? bpc_pkg::TEMP_MAX : $signed(centi_r[14:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ofs_s1_reg   <= $signed({2'd0, t_raw} - {2'd0, t1, 4'd0});
            praw_s1_reg  <= p_raw;
            sq_s2_reg    <= ofs_s1_reg * ofs_s1_reg;
            lin_s2_reg   <= ofs_s1_reg * $signed(t2w[15:0]);
            sqt_s3_reg   <= sq_s2_reg * $signed(t3w[15:0]);
            lins_s3_reg  <= $signed({lin_s2_reg[37], lin_s2_reg[37], lin_s2_reg, 20'd0});
            n34_s4_reg   <= sqt_s3_reg + lins_s3_reg;
            n5_s5_reg    <= (63'(n34_s4_reg) <<< 2) + 63'(n34_s4_reg);
            tf_s5_reg    <= tf_next;
            centi_s6_reg <= centi_next;
        end
    end

    // Pressure chain.
    bpc_mulq u_m1a (.aclk(aclk), .en(adv), .a(tf_s5_reg), .b(p6), .shift(6'd31), .y(m1a_y));
    bpc_mulq u_m1b (.aclk(aclk), .en(adv), .a(tf_s5_reg), .b(p3), .shift(6'd51), .y(m1b_y));
    bpc_mulq u_m2a (.aclk(aclk), .en(adv), .a(x1a_s11_reg), .b(tf_dly_reg[bpc_pkg::TF_DLY-1]),
                    .shift(6'd32), .y(m2a_y));
    bpc_mulq u_m2b (.aclk(aclk), .en(adv), .a(qa_s11_reg), .b(tf_dly_reg[bpc_pkg::TF_DLY-1]),
                    .shift(6'd32), .y(m2b_y));
    bpc_mulq u_m3  (.aclk(aclk), .en(adv), .a(qb_s17_reg), .b($signed({48'd0, p1})),
                    .shift(6'd0), .y(den_y));
    bpc_div  u_div (.aclk(aclk), .en(adv), .num(num_dly_reg[bpc_pkg::NUM_DLY-1]), .den(den_y),
                    .quo(qd_y));
    bpc_mulq u_m4  (.aclk(aclk), .en(adv), .a(qd_y), .b(-64'sd100000), .shift(6'd0), .y(pf_y));
    bpc_mulq u_m5  (.aclk(aclk), .en(adv), .a(pf_y), .b(p9), .shift(6'd35), .y(m5_y));
    bpc_mulq u_m6  (.aclk(aclk), .en(adv), .a(prb_s101_reg), .b(pf_dly_reg[bpc_pkg::PF_DLY-1]),
                    .shift(6'd32), .y(m6_y));

    assign p4_term = ((p4 <<< 4) - 64'sd1048576) <<< 32;

    always_comb begin
        pq8_r = 41'(({1'b0, prc_s107_reg[62:0]} + 64'd8388608) >> 24);
        if (prc_s107_reg[63]) begin
            pq8_next = '0;
        end else if (pq8_r > {16'd0, bpc_pkg::PRESS_MAX}) begin
            pq8_next = bpc_pkg::PRESS_MAX;
        end else begin
            pq8_next = pq8_r[24:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            tf_dly_reg[0]    <= tf_s5_reg;
            praw_dly_reg[0]  <= praw_s1_reg;
            num_dly_reg[0]   <= num_s18_reg;
            pf_dly_reg[0]    <= pf_y;
            centi_dly_reg[0] <= centi_s6_reg;
            nz_dly_reg[0]    <= (den_y != 64'sd0);
            for (int j = 1; j < bpc_pkg::TF_DLY; j++)    tf_dly_reg[j]    <= tf_dly_reg[j-1];
            for (int j = 1; j < bpc_pkg::PRAW_DLY; j++)  praw_dly_reg[j]  <= praw_dly_reg[j-1];
            for (int j = 1; j < bpc_pkg::NUM_DLY; j++)   num_dly_reg[j]   <= num_dly_reg[j-1];
            for (int j = 1; j < bpc_pkg::PF_DLY; j++)    pf_dly_reg[j]    <= pf_dly_reg[j-1];
            for (int j = 1; j < bpc_pkg::CENTI_DLY; j++) centi_dly_reg[j] <= centi_dly_reg[j-1];
            for (int j = 1; j < bpc_pkg::NZ_DLY; j++)    nz_dly_reg[j]    <= nz_dly_reg[j-1];

            x1a_s11_reg  <= bpc_pkg::add_sat(m1a_y, p5 <<< 18);
            qa_s11_reg   <= bpc_pkg::add_sat(m1b_y, p2 <<< 1);
            x1_s17_reg   <= bpc_pkg::add_sat(m2a_y, p4_term);
            qb_s17_reg   <= bpc_pkg::add_sat(m2b_y, bpc_pkg::Q_SIXTEEN);
            num_s18_reg  <= bpc_pkg::add_sat(
                                $signed({12'd0, praw_dly_reg[bpc_pkg::PRAW_DLY-1], 32'd0}),
                                x1_s17_reg);
            pra_s100_reg <= bpc_pkg::add_sat(m5_y, p8 <<< 13);
            prb_s101_reg <= bpc_pkg::add_sat(pra_s100_reg, bpc_pkg::Q_ONE);
            prc_s107_reg <= bpc_pkg::add_sat(m6_y, p7 <<< 28);
            pq8_s108_reg <= pq8_next;
        end
    end

    // Output register; a zero divisor forces the pressure to zero.
    always_ff @(posedge aclk) begin
        if (!m_valid_reg || m_axis_tready) begin
            centi_out_reg <= centi_dly_reg[bpc_pkg::CENTI_DLY-1];
            valid_out_reg <= nz_dly_reg[bpc_pkg::NZ_DLY-1];
            press_out_reg <= nz_dly_reg[bpc_pkg::NZ_DLY-1] ? pq8_s108_reg : 25'd0;
        end
    end

endmodule

/* bench/tb_top.sv */
// Self-checking bench for baro_pressure_temp_compensation: random and directed raw sample
// beats are checked against a Q32 fixed-point compensation computed inside the bench.
// Depends on bpc_pkg and the RTL of the block.
module tb_top;

    typedef struct packed {
        logic [14:0] centi;
        logic [24:0] press;
        logic        ok;
    } comp_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        cfg_wen = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [63:0] cfg_wdata = '0;

    logic [47:0] raw_q[$];
    comp_t       comp_q[$];
    int          fails = 0;
    int          src_idle_pct = 0;
    int          snk_stall_pct = 0;
    logic        s_fired = 1'b0;

    // Bench copy of the calibration registers.
    logic [47:0] cal_temp_m = '0;
    logic [63:0] cal_pa_m = '0;
    logic [63:0] cal_pb_m = '0;
    logic [15:0] cal_pc_m = '0;

    always #6 aclk = ~aclk;

    baro_pressure_temp_compensation dut (.*);

    function automatic bpc_pkg::q32_t word16(input logic [63:0] r, input int pos);
        return {{48{r[pos*16+15]}}, r[pos*16 +: 16]};
    endfunction

    // round(a*b / 2^s), half away from zero, clamped to +-(2^63-1).
    function automatic bpc_pkg::q32_t mul_round(input bpc_pkg::q32_t a, input bpc_pkg::q32_t b,
                                                input int s);
        logic [127:0]  p;
        logic [63:0]   ua, ub;
        bpc_pkg::q32_t r;
        ua = a[63] ? -a : a;
        ub = b[63] ? -b : b;
        p = {64'b0, ua} * {64'b0, ub};
        if (s > 0) begin
            p = p + (128'd1 << (s - 1));
            p = p >> s;
        end
        r = (p > {64'b0, bpc_pkg::Q_MAX}) ? bpc_pkg::Q_MAX : bpc_pkg::q32_t'(p[63:0]);
        return (a[63] != b[63]) ? -r : r;
    endfunction

    // round(num*2^32 / den), half away from zero, clamped.
    function automatic bpc_pkg::q32_t div_round(input bpc_pkg::q32_t num,
                                                input bpc_pkg::q32_t den);
        logic [127:0]  n, d, qt, rm;
        logic [63:0]   un, ud;
        bpc_pkg::q32_t r;
        un = num[63] ? -num : num;
        ud = den[63] ? -den : den;
        n = {32'b0, un, 32'b0};
        d = {64'b0, ud};
        qt = n / d;
        rm = n % d;
        if (rm >= d - rm) qt = qt + 1;
        r = (qt > {64'b0, bpc_pkg::Q_MAX}) ? bpc_pkg::Q_MAX : bpc_pkg::q32_t'(qt[63:0]);
        return (num[63] != den[63]) ? -r : r;
    endfunction

    function automatic bpc_pkg::q32_t sum_clamp(input bpc_pkg::q32_t a, input bpc_pkg::q32_t b);
        logic signed [64:0] s;
        s = a;
        s = s + b;
        if (s > bpc_pkg::Q_MAX) return bpc_pkg::Q_MAX;
        if (s < bpc_pkg::Q_NEG_MAX) return bpc_pkg::Q_NEG_MAX;
        return bpc_pkg::q32_t'(s[63:0]);
    endfunction

    function automatic comp_t compensate(input logic [47:0] d);
        bpc_pkg::q32_t t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        bpc_pkg::q32_t p_raw, t_raw, ofs, n34, c, tf, x1, qd, num, den, pf, pr, pq;
        comp_t r;
        t1 = {48'b0, cal_temp_m[15:0]};
        t2 = word16(64'(cal_temp_m), 1);
        t3 = word16(64'(cal_temp_m), 2);
        p1 = {48'b0, cal_pa_m[15:0]};
        p2 = word16(cal_pa_m, 1);
        p3 = word16(cal_pa_m, 2);
        p4 = word16(cal_pa_m, 3);
        p5 = word16(cal_pb_m, 0);
        p6 = word16(cal_pb_m, 1);
        p7 = word16(cal_pb_m, 2);
        p8 = word16(cal_pb_m, 3);
        p9 = {{48{cal_pc_m[15]}}, cal_pc_m};
        p_raw = {44'b0, d[7:0], d[15:8], d[23:20]};
        t_raw = {44'b0, d[31:24], d[39:32], d[47:44]};

        ofs = t_raw - 16 * t1;
        n34 = ofs * ofs * t3 + ((ofs * t2) <<< 20);
        c = mul_round(n34, 5, 42);
        if (c < -4000) c = -4000;
        if (c > 8500) c = 8500;
        r.centi = c[14:0];

        tf = mul_round(n34, 1, 2) - bpc_pkg::TF_OFFSET;
        x1 = sum_clamp(mul_round(tf, p6, 31), p5 <<< 18);
        x1 = sum_clamp(mul_round(x1, tf, 32), (16 * p4 - 1048576) <<< 32);
        qd = sum_clamp(mul_round(tf, p3, 51), 2 * p2);
        qd = sum_clamp(mul_round(qd, tf, 32), bpc_pkg::Q_SIXTEEN);
        num = sum_clamp(p_raw <<< 32, x1);
        den = mul_round(qd, p1, 0);

        r.press = '0;
        r.ok = 1'b0;
        if (den != 0) begin
            r.ok = 1'b1;
            pf = mul_round(div_round(num, den), -100000, 0);
            pr = sum_clamp(mul_round(pf, p9, 35), p8 <<< 13);
            pr = sum_clamp(pr, bpc_pkg::Q_ONE);
            pr = sum_clamp(mul_round(pr, pf, 32), p7 <<< 28);
            pq = mul_round(pr, 1, 24);
            if (pq < 0) pq = 0;
            if (pq > 33554431) pq = 33554431;
            r.press = pq[24:0];
        end
        return r;
    endfunction

    task automatic report(input string what, input logic [39:0] got, input logic [39:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        fails++;
    endtask

    // Sender: a beat stays on the bus until it has been taken.
    always @(negedge aclk) begin
        logic nv;
        nv = s_axis_tvalid && !s_fired;
        if (!nv && raw_q.size() > 0 && aresetn)
            nv = ($urandom_range(99) >= src_idle_pct);
        s_axis_tvalid <= nv;
        if (nv) s_axis_tdata <= raw_q[0];
        m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    always @(posedge aclk) begin
        s_fired <= s_axis_tvalid && s_axis_tready;
        if (s_axis_tvalid && s_axis_tready) begin
            comp_q.push_back(compensate(raw_q[0]));
            void'(raw_q.pop_front());
        end
    end

    always @(posedge aclk) begin
        comp_t w;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (comp_q.size() == 0) begin
                report("unexpected beat", m_axis_tdata, '0);
            end else begin
                w = comp_q.pop_front();
                if (m_axis_tdata[14:0] != w.centi)
                    report("temperature", 40'(m_axis_tdata[14:0]), 40'(w.centi));
                if (m_axis_tdata[39:15] != w.press)
                    report("pressure", 40'(m_axis_tdata[39:15]), 40'(w.press));
                if (m_axis_tuser[0] != w.ok)
                    report("valid flag", 40'(m_axis_tuser), 40'(w.ok));
            end
        end
    end

    task automatic write_reg(input bpc_pkg::cfg_idx_t idx, input logic [63:0] val);
        @(negedge aclk);
        cfg_wen = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        case (idx)
            bpc_pkg::CFG_CAL_TEMP: begin
                cal_temp_m = val[47:0];
            end
            bpc_pkg::CFG_CAL_PRESS_A: begin
                cal_pa_m = val;
            end
            bpc_pkg::CFG_CAL_PRESS_B: begin
                cal_pb_m = val;
            end
            default: begin
                cal_pc_m = val[15:0];
            end
        endcase
        @(negedge aclk);
        cfg_wen = 1'b0;
    endtask

    task automatic drain;
        while (raw_q.size() > 0 || comp_q.size() > 0) @(posedge aclk);
    endtask

    task automatic typical_cal(input bit jitter);
        logic [15:0] w[12];
        int          k;
        w = '{16'd27504, 16'd26435, -16'sd1000, 16'd36477, -16'sd10685, 16'd3024,
              16'd2855, 16'd140, -16'sd7, 16'd15500, -16'sd14600, 16'd6000};
        if (jitter)
            for (k = 0; k < 12; k++) w[k] = w[k] + 16'($urandom_range(64)) - 16'd32;
        write_reg(bpc_pkg::CFG_CAL_TEMP, {16'b0, w[2], w[1], w[0]});
        write_reg(bpc_pkg::CFG_CAL_PRESS_A, {w[6], w[5], w[4], w[3]});
        write_reg(bpc_pkg::CFG_CAL_PRESS_B, {w[10], w[9], w[8], w[7]});
        write_reg(bpc_pkg::CFG_CAL_PRESS_C, {48'b0, w[11]});
    endtask

    // Mostly plausible raw codes around room conditions, the rest anything at all.
    task automatic queue_random(input int n);
        int          k;
        logic [19:0] pr, tr;
        for (k = 0; k < n; k++) begin
            if ($urandom_range(99) < 65) begin
                pr = 20'($urandom_range(600000, 250000));
                tr = 20'($urandom_range(600000, 400000));
                raw_q.push_back({tr[3:0], 4'($urandom), tr[11:4], tr[19:12],
                                 pr[3:0], 4'($urandom), pr[11:4], pr[19:12]});
            end else begin
                raw_q.push_back({16'($urandom), 32'($urandom)});
            end
        end
    endtask

    task automatic set_idling(input int ph);
        case (ph % 4)
            0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
            1: begin src_idle_pct = 68; snk_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  snk_stall_pct = 68; end
            default: begin src_idle_pct = 9; snk_stall_pct = 9; end
        endcase
    endtask

    initial begin
        int ph;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Reset calibration: the divisor is zero, so pressure is flagged invalid.
        raw_q.push_back(48'h0);
        raw_q.push_back(48'hFFFF_FFFF_FFFF);
        raw_q.push_back(48'h0F00_000F_0000);
        raw_q.push_back(48'hF000_00F0_0000);
        drain();

        typical_cal(0);
        raw_q.push_back(48'h0);
        raw_q.push_back(48'hFFFF_FFFF_FFFF);
        raw_q.push_back({8'h00, 8'h5B, 8'h7E, 8'hC0, 8'h5A, 8'h65});   // room conditions
        raw_q.push_back({8'h0F, 8'h5B, 8'h7E, 8'hC0, 8'h5A, 8'h65});   // low nibbles ignored
        raw_q.push_back({8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00});   // hot sensor
        raw_q.push_back({8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF});
        raw_q.push_back({8'h50, 8'h55, 8'h60, 8'h10, 8'h20, 8'h30});
        queue_random(200);
        drain();

        // Extreme calibrations: saturations everywhere, then divisor zero via p1.
        write_reg(bpc_pkg::CFG_CAL_TEMP, 64'hFFFF_FFFF_FFFF);
        write_reg(bpc_pkg::CFG_CAL_PRESS_A, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(bpc_pkg::CFG_CAL_PRESS_B, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(bpc_pkg::CFG_CAL_PRESS_C, 64'hFFFF);
        set_idling(1);
        queue_random(120);
        drain();
        write_reg(bpc_pkg::CFG_CAL_TEMP, 64'h8000_7FFF_0000);
        write_reg(bpc_pkg::CFG_CAL_PRESS_A, 64'h7FFF_8000_7FFF_0001);
        write_reg(bpc_pkg::CFG_CAL_PRESS_B, 64'h8000_7FFF_8000_7FFF);
        write_reg(bpc_pkg::CFG_CAL_PRESS_C, 64'h8000);
        set_idling(2);
        queue_random(120);
        drain();
        write_reg(bpc_pkg::CFG_CAL_PRESS_A, 64'h0B27_0BD0_D6B3_0000);
        set_idling(3);
        queue_random(60);
        drain();

        for (ph = 0; ph < 8; ph++) begin
            set_idling(ph);
            if (ph % 3 == 2) begin
                write_reg(bpc_pkg::CFG_CAL_TEMP, {16'($urandom), 32'($urandom)});
                write_reg(bpc_pkg::CFG_CAL_PRESS_A, {32'($urandom), 32'($urandom)});
                write_reg(bpc_pkg::CFG_CAL_PRESS_B, {32'($urandom), 32'($urandom)});
                write_reg(bpc_pkg::CFG_CAL_PRESS_C, 64'($urandom_range(65535)));
            end else begin
                typical_cal(ph != 0);
            end
            queue_random(105);
            drain();
        end

        repeat (150) @(posedge aclk);
        if (fails == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #(12 * 400000);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* baro_pressure_temp_compensation.f */
rtl/bpc_pkg.sv
rtl/bpc_mulq.sv
rtl/bpc_div.sv
rtl/baro_pressure_temp_compensation.sv
bench/tb_top.sv
